// ----- rtl/core/ole_pkg.sv -----
// Shared types and constants for the ordered list engine.
package ole_pkg;

    // List capacity and the widths that follow from it
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request codes
    localparam logic [2:0] REQ_INS_FRONT = 3'd0;
    localparam logic [2:0] REQ_INS_BACK  = 3'd1;
    localparam logic [2:0] REQ_DELETE    = 3'd2;
    localparam logic [2:0] REQ_SEARCH    = 3'd3;
    localparam logic [2:0] REQ_DUMP      = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DUMP,
        S_RESP
    } t_state;

    // Request item
    typedef struct packed {
        logic [2:0]          req_type;
        logic signed [31:0]  value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]          status;
        logic                found;
        logic signed [31:0]  item_value;
        logic                item_valid;
        logic                last_flag;
        logic [4:0]          entry_count;
    } t_out_item;

endpackage

// ----- rtl/core/ordered_list_engine_top.sv -----
// Ordered list engine: bounded in-order list store with a walking sequencer.
// Holds up to ole_pkg::CAPACITY signed 32-bit entries in a single-port-read memory
// (one write, one registered read per cycle) and takes one request at a time;
// o_in_stall is high from the cycle after acceptance until the request's last
// item is loaded into the output register. Insert back, a dropped insert and an
// unused code go straight to the result. Insert front moves every entry one place
// toward the tail. Search and delete scan from the head, stopping on a hit or at
// the tail on a miss; a delete then closes up the tail. A dump gives one item per
// cycle when the output is not stalled. The pace everywhere is set by the memory's
// single read port and its read register. No clearing pass is needed after reset:
// entries at or beyond the length are never read.
module ordered_list_engine_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ole_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ole_pkg::t_out_item  o_out_item
);

    // List store (no reset)
    logic signed [31:0] mem [ole_pkg::CAPACITY];

    // Control state
    ole_pkg::t_state                 r_state, n_state;
    logic [ole_pkg::CNT_W-1:0]       r_len, n_len;
    logic [ole_pkg::CNT_W-1:0]       r_ptr, n_ptr;
    logic [2:0]                      r_req, n_req;
    logic signed [31:0]              r_key, n_key;
    logic [1:0]                      r_resp_status, n_resp_status;
    logic                            r_resp_found, n_resp_found;
    logic                            r_out_valid, n_out_valid;
    ole_pkg::t_out_item              r_out_item, n_out_item;
    logic                            r_rd_vld, n_rd_vld;
    logic [ole_pkg::IDX_W-1:0]       r_rd_idx;
    logic signed [31:0]              r_rd_data;

    // Combinational controls
    logic                            out_free;
    logic                            rd_issue;
    logic                            rd_consume;
    logic [ole_pkg::IDX_W-1:0]       rd_addr;
    logic                            wr_en;
    logic [ole_pkg::IDX_W-1:0]       wr_addr;
    logic signed [31:0]              wr_data;
    logic [ole_pkg::CNT_W-1:0]       ptr_dec;
    logic [ole_pkg::CNT_W-1:0]       rd_idx_next;
    logic                            rd_hit;

    assign ptr_dec     = r_ptr - ole_pkg::CNT_W'(1);
    assign rd_idx_next = ole_pkg::CNT_W'(r_rd_idx) + ole_pkg::CNT_W'(1);
    assign rd_hit      = r_rd_vld && (r_rd_data == r_key);
    assign out_free    = !r_out_valid || !i_out_stall;

    // Sequencer: next state and memory controls
    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_ptr         = r_ptr;
        n_req         = r_req;
        n_key         = r_key;
        n_resp_status = r_resp_status;
        n_resp_found  = r_resp_found;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_item    = r_out_item;
        rd_issue      = 1'b0;
        rd_consume    = 1'b0;
        rd_addr       = r_ptr[ole_pkg::IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = r_ptr[ole_pkg::IDX_W-1:0];
        wr_data       = r_key;

        case (r_state)
            ole_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req         = i_in_item.req_type;
                    n_key         = i_in_item.value;
                    n_resp_status = ole_pkg::STAT_DONE;
                    n_resp_found  = 1'b0;
                    n_ptr         = '0;
                    case (i_in_item.req_type)
                        ole_pkg::REQ_INS_FRONT: begin
                            if (r_len >= ole_pkg::CNT_W'(ole_pkg::CAPACITY)) begin
                                n_resp_status = ole_pkg::STAT_FULL;
                                n_state       = ole_pkg::S_RESP;
                            end else begin
                                n_ptr   = r_len;
                                n_state = ole_pkg::S_SHIFT_DN;
                            end
                        end
                        ole_pkg::REQ_INS_BACK: begin
                            if (r_len >= ole_pkg::CNT_W'(ole_pkg::CAPACITY)) begin
                                n_resp_status = ole_pkg::STAT_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_len[ole_pkg::IDX_W-1:0];
                                wr_data = i_in_item.value;
                                n_len   = r_len + ole_pkg::CNT_W'(1);
                            end
                            n_state = ole_pkg::S_RESP;
                        end
                        ole_pkg::REQ_DELETE, ole_pkg::REQ_SEARCH: begin
                            n_state = ole_pkg::S_SCAN;
                        end
                        ole_pkg::REQ_DUMP: begin
                            n_state = (r_len == '0) ? ole_pkg::S_RESP : ole_pkg::S_DUMP;
                        end
                        default: begin
                            n_state = ole_pkg::S_RESP;
                        end
                    endcase
                end
            end

            // Walk from the head looking for the key
            ole_pkg::S_SCAN: begin
                if (rd_hit) begin
                    rd_consume = 1'b1;
                    if (r_req == ole_pkg::REQ_DELETE) begin
                        n_ptr   = rd_idx_next;
                        n_state = ole_pkg::S_SHIFT_UP;
                    end else begin
                        n_resp_found = 1'b1;
                        n_state      = ole_pkg::S_RESP;
                    end
                end else begin
                    rd_consume = r_rd_vld;
                    if (r_ptr < r_len) begin
                        rd_issue = 1'b1;
                        n_ptr    = r_ptr + ole_pkg::CNT_W'(1);
                    end else if (!r_rd_vld) begin
                        if (r_req == ole_pkg::REQ_DELETE) begin
                            n_resp_status = ole_pkg::STAT_ABSENT;
                        end
                        n_state = ole_pkg::S_RESP;
                    end
                end
            end

            // Close up after a delete: entry i+1 moves to i
            ole_pkg::S_SHIFT_UP: begin
                if (r_rd_vld) begin
                    rd_consume = 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = r_rd_idx - ole_pkg::IDX_W'(1);
                    wr_data    = r_rd_data;
                end
                if (r_ptr < r_len) begin
                    rd_issue = 1'b1;
                    n_ptr    = r_ptr + ole_pkg::CNT_W'(1);
                end else if (!r_rd_vld) begin
                    n_len   = r_len - ole_pkg::CNT_W'(1);
                    n_state = ole_pkg::S_RESP;
                end
            end

            // Open a slot at the head: entry i moves to i+1, tail first
            ole_pkg::S_SHIFT_DN: begin
                if (r_rd_vld) begin
                    rd_consume = 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = r_rd_idx + ole_pkg::IDX_W'(1);
                    wr_data    = r_rd_data;
                end
                if (r_ptr != '0) begin
                    rd_issue = 1'b1;
                    rd_addr  = ptr_dec[ole_pkg::IDX_W-1:0];
                    n_ptr    = ptr_dec;
                end else if (!r_rd_vld) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = r_key;
                    n_len   = r_len + ole_pkg::CNT_W'(1);
                    n_state = ole_pkg::S_RESP;
                end
            end

            // Stream entries head to tail
            ole_pkg::S_DUMP: begin
                if (r_rd_vld && out_free) begin
                    rd_consume             = 1'b1;
                    n_out_valid            = 1'b1;
                    n_out_item.status      = ole_pkg::STAT_DONE;
                    n_out_item.found       = 1'b0;
                    n_out_item.item_value  = r_rd_data;
                    n_out_item.item_valid  = 1'b1;
                    n_out_item.last_flag   = (rd_idx_next == r_len);
                    n_out_item.entry_count = 5'(r_len);
                    if (rd_idx_next == r_len) begin
                        n_state = ole_pkg::S_IDLE;
                    end
                end
                if ((r_ptr < r_len) && (!r_rd_vld || rd_consume)) begin
                    rd_issue = 1'b1;
                    n_ptr    = r_ptr + ole_pkg::CNT_W'(1);
                end
            end

            // Single-item result
            ole_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_item.status      = r_resp_status;
                    n_out_item.found       = r_resp_found;
                    n_out_item.item_value  = '0;
                    n_out_item.item_valid  = 1'b0;
                    n_out_item.last_flag   = 1'b1;
                    n_out_item.entry_count = 5'(r_len);
                    n_state                = ole_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ole_pkg::S_IDLE;
            end
        endcase

        n_rd_vld = rd_issue || (r_rd_vld && !rd_consume);
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ole_pkg::S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ptr         <= n_ptr;
        r_req         <= n_req;
        r_key         <= n_key;
        r_resp_status <= n_resp_status;
        r_resp_found  <= n_resp_found;
        r_out_item    <= n_out_item;
    end

    // Memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_issue) begin
            r_rd_data <= mem[rd_addr];
            r_rd_idx  <= rd_addr;
        end
    end

    assign o_in_stall  = (r_state != ole_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= ole_pkg::CNT_W'(ole_pkg::CAPACITY))
        else $error("list length beyond capacity");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted but engine not busy");

    a_no_read_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ole_pkg::S_IDLE) |-> !r_rd_vld)
        else $error("read data pending while idle");

    a_entry_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.item_valid) |->
            (o_out_item.status == ole_pkg::STAT_DONE && !o_out_item.found))
        else $error("dump item with bad status");

endmodule
